// File: rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is low
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, ignored while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/bbps_pkg.sv
package bbps_pkg;

  localparam int TABLE_ENTRIES_DEF = 64;

  localparam int OP_W       = 2;
  localparam int LAT_W      = 31;
  localparam int LON_W      = 32;
  localparam int HLAT_W     = 30;
  localparam int HLON_W     = 31;
  localparam int IDX_OUT_W  = 6;
  localparam int COUNT_W    = 7;
  localparam int BND_W      = 34;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_LAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_LON = 2'd1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic [IDX_OUT_W-1:0] entry_index;
    logic                 is_match;
    logic                 last;
    logic                 status;
    logic [COUNT_W-1:0]   stored_count;
  } out_item_t;

endpackage

// File: rtl/bbps_in_if.sv
interface bbps_in_if;
  logic                                valid;
  logic                                ready;
  logic [bbps_pkg::OP_W-1:0]           operation;
  logic signed [bbps_pkg::LAT_W-1:0]   point_lat;
  logic signed [bbps_pkg::LON_W-1:0]   point_lon;

  modport source (output valid, output operation, output point_lat, output point_lon,
                  input ready);
  modport sink (input valid, input operation, input point_lat, input point_lon,
                output ready);
endinterface

// File: rtl/bbps_out_if.sv
interface bbps_out_if;
  logic                              valid;
  logic                              ready;
  logic [bbps_pkg::IDX_OUT_W-1:0]    entry_index;
  logic                              is_match;
  logic                              last;
  logic                              status;
  logic [bbps_pkg::COUNT_W-1:0]      stored_count;

  modport source (output valid, output entry_index, output is_match, output last,
                  output status, output stored_count, input ready);
  modport sink (input valid, input entry_index, input is_match, input last,
                input status, input stored_count, output ready);
endinterface

// File: rtl/bbps_cfg_if.sv
interface bbps_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [bbps_pkg::CFG_IDX_W-1:0]     reg_index;
  logic [bbps_pkg::CFG_DATA_W-1:0]    wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

// File: rtl/bounding_box_point_search.sv
// clear and append: result registered in the cycle after the input transfer
// query: bounds registered from the query point, then one table entry per cycle through the
//   single read port and shared range compare; a stalled output pauses the walk, but only
//   when a new hit meets a held one while the output register is not free
// next item is taken once the previous item's final result has left the output register or is being accepted
// reset: count, windows and control cleared; table contents undefined until written
`include "assert_macros.svh"

module bounding_box_point_search #(
  parameter int TABLE_ENTRIES = bbps_pkg::TABLE_ENTRIES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bbps_in_if.sink      in_ch,
  bbps_out_if.source   out_ch,
  bbps_cfg_if.sink     cfg_ch
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int BND_W = bbps_pkg::BND_W;
  localparam int COUNT_W = bbps_pkg::COUNT_W;
  localparam logic [COUNT_W-1:0] DEPTH = COUNT_W'(TABLE_ENTRIES);

  localparam int ST_W = 2;
  localparam logic [ST_W-1:0] S_IDLE   = 2'd0;
  localparam logic [ST_W-1:0] S_QUERY  = 2'd1;
  localparam logic [ST_W-1:0] S_FINISH = 2'd2;

  logic [ST_W-1:0]                     state_r, state_nxt;
  logic [COUNT_W-1:0]                  fill_count_r, fill_count_nxt;
  logic [bbps_pkg::HLAT_W-1:0]         half_lat_r, half_lat_nxt;
  logic [bbps_pkg::HLON_W-1:0]         half_lon_r, half_lon_nxt;
  logic signed [BND_W-1:0]             lat_lo_r, lat_lo_nxt, lat_hi_r, lat_hi_nxt;
  logic signed [BND_W-1:0]             lon_lo_r, lon_lo_nxt, lon_hi_r, lon_hi_nxt;
  logic [COUNT_W-1:0]                  rd_idx_r, rd_idx_nxt;
  logic                                cmp_valid_r, cmp_valid_nxt;
  logic [bbps_pkg::IDX_OUT_W-1:0]      cmp_idx_r, cmp_idx_nxt;
  logic                                pend_valid_r, pend_valid_nxt;
  logic [bbps_pkg::IDX_OUT_W-1:0]      pend_idx_r, pend_idx_nxt;
  logic                                out_valid_r, out_valid_nxt;
  bbps_pkg::out_item_t                 out_item_r, out_item_nxt;
  logic                                out_load;

  logic [bbps_pkg::LAT_W-1:0]          lat_mem [TABLE_ENTRIES];
  logic [bbps_pkg::LON_W-1:0]          lon_mem [TABLE_ENTRIES];
  logic [bbps_pkg::LAT_W-1:0]          rd_lat_r;
  logic [bbps_pkg::LON_W-1:0]          rd_lon_r;
  logic                                mem_we, mem_re;

  logic                                out_free, in_ready, in_fire, cfg_fire;
  logic                                table_full, more, hit, stall;
  logic signed [BND_W-1:0]             q_lat, q_lon, h_lat, h_lon, t_lat, t_lon;

  assign out_free   = !out_valid_r || out_ch.ready;
  assign in_ready   = (state_r == S_IDLE) && out_free;
  assign in_fire    = in_ch.valid && in_ready;
  assign cfg_fire   = cfg_ch.valid;
  assign table_full = (fill_count_r >= DEPTH);
  assign more       = (rd_idx_r < fill_count_r);

  assign q_lat = $signed({{(BND_W-bbps_pkg::LAT_W){in_ch.point_lat[bbps_pkg::LAT_W-1]}},
                          in_ch.point_lat});
  assign q_lon = $signed({{(BND_W-bbps_pkg::LON_W){in_ch.point_lon[bbps_pkg::LON_W-1]}},
                          in_ch.point_lon});
  assign h_lat = $signed({{(BND_W-bbps_pkg::HLAT_W){1'b0}}, half_lat_r});
  assign h_lon = $signed({{(BND_W-bbps_pkg::HLON_W){1'b0}}, half_lon_r});
  assign t_lat = $signed({{(BND_W-bbps_pkg::LAT_W){rd_lat_r[bbps_pkg::LAT_W-1]}}, rd_lat_r});
  assign t_lon = $signed({{(BND_W-bbps_pkg::LON_W){rd_lon_r[bbps_pkg::LON_W-1]}}, rd_lon_r});

  // shared range compare on the entry just read
  assign hit = cmp_valid_r && (t_lat >= lat_lo_r) && (t_lat <= lat_hi_r)
                           && (t_lon >= lon_lo_r) && (t_lon <= lon_hi_r);
  assign stall = hit && pend_valid_r && !out_free;

  assign mem_we = in_fire && (in_ch.operation == bbps_pkg::OP_APPEND) && !table_full;
  assign mem_re = (state_r == S_QUERY) && !stall && more;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      lat_mem[fill_count_r[IDX_W-1:0]] <= in_ch.point_lat;
      lon_mem[fill_count_r[IDX_W-1:0]] <= in_ch.point_lon;
    end
    if (mem_re) begin
      rd_lat_r <= lat_mem[rd_idx_r[IDX_W-1:0]];
      rd_lon_r <= lon_mem[rd_idx_r[IDX_W-1:0]];
    end
  end

  always_comb begin
    half_lat_nxt = half_lat_r;
    half_lon_nxt = half_lon_r;
    if (cfg_fire) begin
      unique case (cfg_ch.reg_index)
        bbps_pkg::REG_HALF_LAT: half_lat_nxt = cfg_ch.wr_data[bbps_pkg::HLAT_W-1:0];
        bbps_pkg::REG_HALF_LON: half_lon_nxt = cfg_ch.wr_data[bbps_pkg::HLON_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt      = state_r;
    fill_count_nxt = fill_count_r;
    lat_lo_nxt     = lat_lo_r;
    lat_hi_nxt     = lat_hi_r;
    lon_lo_nxt     = lon_lo_r;
    lon_hi_nxt     = lon_hi_r;
    rd_idx_nxt     = rd_idx_r;
    cmp_valid_nxt  = cmp_valid_r;
    cmp_idx_nxt    = cmp_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_idx_nxt   = pend_idx_r;
    out_load       = 1'b0;
    out_item_nxt   = out_item_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.operation)
            bbps_pkg::OP_CLEAR: begin
              fill_count_nxt = '0;
              out_load       = 1'b1;
              out_item_nxt   = '{entry_index: '0, is_match: 1'b0, last: 1'b1,
                                 status: bbps_pkg::STATUS_OK, stored_count: '0};
            end
            bbps_pkg::OP_APPEND: begin
              out_load = 1'b1;
              if (table_full) begin
                out_item_nxt = '{entry_index: '0, is_match: 1'b0, last: 1'b1,
                                 status: bbps_pkg::STATUS_FULL,
                                 stored_count: fill_count_r};
              end else begin
                fill_count_nxt = fill_count_r + 1'b1;
                out_item_nxt   = '{entry_index: fill_count_r[bbps_pkg::IDX_OUT_W-1:0],
                                   is_match: 1'b0, last: 1'b1,
                                   status: bbps_pkg::STATUS_OK,
                                   stored_count: fill_count_r + 1'b1};
              end
            end
            bbps_pkg::OP_QUERY: begin
              lat_lo_nxt     = q_lat - h_lat;
              lat_hi_nxt     = q_lat + h_lat;
              lon_lo_nxt     = q_lon - h_lon;
              lon_hi_nxt     = q_lon + h_lon;
              rd_idx_nxt     = '0;
              cmp_valid_nxt  = 1'b0;
              pend_valid_nxt = 1'b0;
              state_nxt      = S_QUERY;
            end
            default: ;
          endcase
        end
      end
      S_QUERY: begin
        if (!stall) begin
          cmp_valid_nxt = more;
          cmp_idx_nxt   = rd_idx_r[bbps_pkg::IDX_OUT_W-1:0];
          if (more) begin
            rd_idx_nxt = rd_idx_r + 1'b1;
          end
          // a new hit releases the held one, which is then known not to be last
          if (hit) begin
            if (pend_valid_r) begin
              out_load     = 1'b1;
              out_item_nxt = '{entry_index: pend_idx_r, is_match: 1'b1, last: 1'b0,
                               status: bbps_pkg::STATUS_OK, stored_count: fill_count_r};
            end
            pend_valid_nxt = 1'b1;
            pend_idx_nxt   = cmp_idx_r;
          end
          if (!more && !cmp_valid_r) begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          if (pend_valid_r) begin
            out_item_nxt = '{entry_index: pend_idx_r, is_match: 1'b1, last: 1'b1,
                             status: bbps_pkg::STATUS_OK, stored_count: fill_count_r};
          end else begin
            out_item_nxt = '{entry_index: '0, is_match: 1'b0, last: 1'b1,
                             status: bbps_pkg::STATUS_OK, stored_count: fill_count_r};
          end
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_valid_nxt = out_load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_count_r <= '0;
      half_lat_r   <= '0;
      half_lon_r   <= '0;
      rd_idx_r     <= '0;
      cmp_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fill_count_r <= fill_count_nxt;
      half_lat_r   <= half_lat_nxt;
      half_lon_r   <= half_lon_nxt;
      rd_idx_r     <= rd_idx_nxt;
      cmp_valid_r  <= cmp_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lat_lo_r   <= lat_lo_nxt;
    lat_hi_r   <= lat_hi_nxt;
    lon_lo_r   <= lon_lo_nxt;
    lon_hi_r   <= lon_hi_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    pend_idx_r <= pend_idx_nxt;
    out_item_r <= out_item_nxt;
  end

  assign in_ch.ready         = in_ready;
  assign cfg_ch.ready        = 1'b1;
  assign out_ch.valid        = out_valid_r;
  assign out_ch.entry_index  = out_item_r.entry_index;
  assign out_ch.is_match     = out_item_r.is_match;
  assign out_ch.last         = out_item_r.last;
  assign out_ch.status       = out_item_r.status;
  assign out_ch.stored_count = out_item_r.stored_count;

  `ASSERT_IMPLIES(a_fill_bound, clk, rst_n, 1'b1, fill_count_r <= DEPTH)
  `ASSERT_IMPLIES(a_walk_bound, clk, rst_n, state_r == S_QUERY, rd_idx_r <= fill_count_r)
  `ASSERT_IMPLIES(a_pend_stored, clk, rst_n, pend_valid_r,
                  COUNT_W'(pend_idx_r) < fill_count_r)
  `ASSERT_IMPLIES(a_match_stored, clk, rst_n, out_valid_r && out_item_r.is_match,
                  (COUNT_W'(out_item_r.entry_index) < out_item_r.stored_count) &&
                  (out_item_r.status == bbps_pkg::STATUS_OK))
  `ASSERT_NEXT(a_finish_emits, clk, rst_n, (state_r == S_FINISH) && out_free,
               out_valid_r && out_item_r.last && (state_r == S_IDLE))

endmodule

// File: test/bbps_result_checker.sv
`timescale 1ns / 1ps

module bbps_result_checker (
  input  logic clk,
  input  logic rst_n,
  bbps_in_if   in_ch,
  bbps_out_if  out_ch,
  bbps_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending_count
);
  import bbps_pkg::*;

  logic signed [LAT_W-1:0] lat_tbl [TABLE_ENTRIES_DEF];
  logic signed [LON_W-1:0] lon_tbl [TABLE_ENTRIES_DEF];
  logic [COUNT_W-1:0]      fill;
  logic [HLAT_W-1:0]       half_lat;
  logic [HLON_W-1:0]       half_lon;
  out_item_t               pending_results [$];
  int                      mismatch_total = 0;

  function automatic string show(out_item_t r);
    return $sformatf("idx=%0d match=%0b last=%0b status=%0b count=%0d",
                     r.entry_index, r.is_match, r.last, r.status, r.stored_count);
  endfunction

  function automatic void add_expected(out_item_t r);
    pending_results.insert(pending_results.size(), r);
  endfunction

  function automatic void predict_results(logic [OP_W-1:0] op,
                                          logic signed [LAT_W-1:0] lat,
                                          logic signed [LON_W-1:0] lon);
    longint    lat_lo;
    longint    lat_hi;
    longint    lon_lo;
    longint    lon_hi;
    int        hits;
    int        i;
    out_item_t r;
    r = '0;
    r.last = 1'b1;
    r.status = STATUS_OK;
    case (op)
      OP_CLEAR: begin
        fill = '0;
        add_expected(r);
      end
      OP_APPEND: begin
        if (fill >= TABLE_ENTRIES_DEF) begin
          r.status = STATUS_FULL;
        end else begin
          lat_tbl[fill[IDX_OUT_W-1:0]] = lat;
          lon_tbl[fill[IDX_OUT_W-1:0]] = lon;
          r.entry_index = fill[IDX_OUT_W-1:0];
          fill = fill + 1'b1;
        end
        r.stored_count = fill;
        add_expected(r);
      end
      OP_QUERY: begin
        lat_lo = longint'(lat) - longint'(half_lat);
        lat_hi = longint'(lat) + longint'(half_lat);
        lon_lo = longint'(lon) - longint'(half_lon);
        lon_hi = longint'(lon) + longint'(half_lon);
        hits = 0;
        r.stored_count = fill;
        for (i = 0; i < fill; i++) begin
          if (lat_lo <= longint'(lat_tbl[i[IDX_OUT_W-1:0]]) &&
              longint'(lat_tbl[i[IDX_OUT_W-1:0]]) <= lat_hi &&
              lon_lo <= longint'(lon_tbl[i[IDX_OUT_W-1:0]]) &&
              longint'(lon_tbl[i[IDX_OUT_W-1:0]]) <= lon_hi) begin
            r.entry_index = i[IDX_OUT_W-1:0];
            r.is_match = 1'b1;
            r.last = 1'b0;
            add_expected(r);
            hits++;
          end
        end
        if (hits == 0) begin
          r.entry_index = '0;
          r.is_match = 1'b0;
          r.last = 1'b1;
          add_expected(r);
        end else begin
          pending_results[pending_results.size() - 1].last = 1'b1;
        end
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t got;
    out_item_t want;
    if (!rst_n) begin
      fill = '0;
      half_lat = '0;
      half_lon = '0;
      pending_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          REG_HALF_LAT: half_lat = cfg_ch.wr_data[HLAT_W-1:0];
          REG_HALF_LON: half_lon = cfg_ch.wr_data[HLON_W-1:0];
          default: begin
          end
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got.entry_index  = out_ch.entry_index;
        got.is_match     = out_ch.is_match;
        got.last         = out_ch.last;
        got.status       = out_ch.status;
        got.stored_count = out_ch.stored_count;
        if (pending_results.size() == 0) begin
          mismatch_total++;
          if (mismatch_total <= 10)
            $display("%0t unexpected result transfer: got %s", $time, show(got));
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatch_total++;
            if (mismatch_total <= 10)
              $display("%0t result mismatch: expected %s, got %s", $time, show(want),
                       show(got));
          end
        end
      end
      if (in_ch.valid && in_ch.ready)
        predict_results(in_ch.operation, in_ch.point_lat, in_ch.point_lon);
    end
    fail_count    <= mismatch_total;
    pending_count <= pending_results.size();
  end

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bbps_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam longint LAT_LIMIT = 900000000;
  localparam longint LON_LIMIT = 1800000000;
  localparam longint LAT_TOP = (64'sd1 <<< (LAT_W - 1)) - 1;
  localparam longint LON_TOP = (64'sd1 <<< (LON_W - 1)) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycle_count = 0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  int   fail_count;
  int   pending_count;

  logic signed [LAT_W-1:0] kept_lat [TABLE_ENTRIES_DEF];
  logic signed [LON_W-1:0] kept_lon [TABLE_ENTRIES_DEF];
  int                      kept_n = 0;
  longint                  center_lat;
  longint                  center_lon;
  logic [HLAT_W-1:0]       cur_hlat = '0;
  logic [HLON_W-1:0]       cur_hlon = '0;

  bbps_in_if  in_ch ();
  bbps_out_if out_ch ();
  bbps_cfg_if cfg_ch ();

  bounding_box_point_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bbps_result_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) out_ch.ready <= rst_n && ($urandom_range(99) >= out_stall_pct);

  function automatic longint clamp(longint v, longint top);
    if (v > top) return top;
    if (v < -top - 1) return -top - 1;
    return v;
  endfunction

  function automatic longint rand_coord(longint center, longint spread, longint span,
                                        longint top);
    int pick;
    pick = $urandom_range(9);
    if (pick < 7) return clamp(center + longint'($urandom_range(2 * spread)) - spread, top);
    if (pick < 9) return longint'($urandom_range(2 * span)) - span;
    return longint'($urandom());
  endfunction

  // points at, on and just past the box edges around a stored point
  function automatic longint near_coord(longint base, longint half_w, longint top);
    case ($urandom_range(4))
      0: return base;
      1: return clamp(base + half_w, top);
      2: return clamp(base - half_w, top);
      3: return clamp(base + half_w + 1, top);
      default: return clamp(base - half_w - 1, top);
    endcase
  endfunction

  task automatic send_point_item(logic [OP_W-1:0] op, longint lat, longint lon);
    while ($urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.point_lat <= LAT_W'(lat);
    in_ch.point_lon <= LON_W'(lon);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_CLEAR) begin
      kept_n = 0;
    end else if (op == OP_APPEND && kept_n < TABLE_ENTRIES_DEF) begin
      kept_lat[kept_n[IDX_OUT_W-1:0]] = LAT_W'(lat);
      kept_lon[kept_n[IDX_OUT_W-1:0]] = LON_W'(lon);
      kept_n++;
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_windows(logic [CFG_DATA_W-1:0] lat_w, logic [CFG_DATA_W-1:0] lon_w);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= REG_HALF_LAT;
    cfg_ch.wr_data   <= lat_w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.reg_index <= REG_HALF_LON;
    cfg_ch.wr_data   <= lon_w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    cur_hlat = lat_w[HLAT_W-1:0];
    cur_hlon = lon_w[HLON_W-1:0];
    center_lat = longint'($urandom_range(2 * LAT_LIMIT)) - LAT_LIMIT;
    center_lon = longint'($urandom_range(2 * LON_LIMIT)) - LON_LIMIT;
  endtask

  task automatic run_phase(int n_items, int idle_pct, int stall_pct);
    int          sent;
    int          pick;
    int          k;
    longint      spread_lat;
    longint      spread_lon;
    longint      q_lat;
    longint      q_lon;
    logic [OP_W-1:0] op;
    sent = 0;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    spread_lat = clamp(2 * longint'(cur_hlat) + 1000, 1000000000);
    spread_lon = clamp(2 * longint'(cur_hlon) + 1000, 1000000000);
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 4) op = OP_CLEAR;
      else if (pick < 8) op = OP_UNUSED;
      else if (pick < 50) op = OP_APPEND;
      else op = OP_QUERY;
      if (op == OP_QUERY && kept_n > 0 && $urandom_range(1)) begin
        k = $urandom_range(kept_n - 1);
        q_lat = near_coord(kept_lat[k[IDX_OUT_W-1:0]], cur_hlat, LAT_TOP);
        q_lon = near_coord(kept_lon[k[IDX_OUT_W-1:0]], cur_hlon, LON_TOP);
      end else begin
        q_lat = rand_coord(center_lat, spread_lat, LAT_LIMIT, LAT_TOP);
        q_lon = rand_coord(center_lon, spread_lon, LON_LIMIT, LON_TOP);
      end
      send_point_item(op, q_lat, q_lon);
      if (op != OP_UNUSED) sent++;
    end
    drain_results();
  endtask

  initial begin
    logic signed [LAT_W-1:0] lat_min;
    logic signed [LAT_W-1:0] lat_max;
    logic signed [LON_W-1:0] lon_min;
    logic signed [LON_W-1:0] lon_max;
    lat_min = {1'b1, {(LAT_W - 1){1'b0}}};
    lat_max = {1'b0, {(LAT_W - 1){1'b1}}};
    lon_min = {1'b1, {(LON_W - 1){1'b0}}};
    lon_max = {1'b0, {(LON_W - 1){1'b1}}};
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_CLEAR;
    in_ch.point_lat  = '0;
    in_ch.point_lon  = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_HALF_LAT;
    cfg_ch.wr_data   = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero windows after reset: exact hits only
    send_point_item(OP_CLEAR, 0, 0);
    send_point_item(OP_QUERY, 0, 0);
    send_point_item(OP_APPEND, -LAT_LIMIT, -LON_LIMIT);
    send_point_item(OP_APPEND, LAT_LIMIT, LON_LIMIT);
    send_point_item(OP_APPEND, 0, 0);
    send_point_item(OP_APPEND, lat_min, lon_min);
    send_point_item(OP_APPEND, lat_max, lon_max);
    send_point_item(OP_UNUSED, lat_max, lon_min);
    send_point_item(OP_QUERY, 0, 0);
    send_point_item(OP_QUERY, LAT_LIMIT, LON_LIMIT);
    send_point_item(OP_QUERY, lat_min, lon_min);
    send_point_item(OP_QUERY, 1, 0);
    drain_results();

    set_windows(CFG_DATA_W'(LAT_LIMIT), CFG_DATA_W'(LON_LIMIT));
    send_point_item(OP_QUERY, 0, 0);
    send_point_item(OP_QUERY, lat_max, lon_max);
    send_point_item(OP_QUERY, lat_min, lon_min);
    send_point_item(OP_APPEND, 12345, -67890);
    send_point_item(OP_CLEAR, lat_max, lon_max);
    send_point_item(OP_QUERY, 0, 0);
    drain_results();

    set_windows($urandom_range(5000000), $urandom_range(10000000));
    run_phase(35, 0, 0);

    set_windows(CFG_DATA_W'(LAT_LIMIT), CFG_DATA_W'(LON_LIMIT));
    run_phase(35, 69, 0);

    // fill the table past full, then query it
    set_windows($urandom_range(200000000), $urandom_range(400000000));
    in_idle_pct = 0;
    out_stall_pct = 69;
    send_point_item(OP_CLEAR, 0, 0);
    repeat (TABLE_ENTRIES_DEF + 2)
      send_point_item(OP_APPEND,
                      rand_coord(center_lat, 2 * longint'(cur_hlat) + 1000, LAT_LIMIT,
                                 LAT_TOP),
                      rand_coord(center_lon, 2 * longint'(cur_hlon) + 1000, LON_LIMIT,
                                 LON_TOP));
    run_phase(30, 0, 69);

    set_windows(32'hffff_ffff, 32'hffff_ffff);
    run_phase(35, 22, 22);

    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
